// ----- rtl/lfhp_pkg.sv -----
// shared types and constants for the frame header parser
// no dependencies
package lfhp_pkg;

	localparam int JOIN_MIN_LEN = 1 + 3 + 3 + 4 + 1 + 1 + 4;
	localparam int JOIN_MAX_LEN = 1 + 3 + 3 + 4 + 1 + 1 + 4 + 16;
	localparam int ACCEPT_LEN   = 1 + 8 + 8 + 2 + 4;
	localparam int DATA_MIN_LEN = 1 + 4 + 1 + 2 + 4;

	localparam logic [4:0] VERSION_MASK = 5'b11111;
	localparam logic [3:0] FOPTS_MASK   = 4'hF;
	localparam logic [7:0] NO_PORT      = 8'hFF;
	localparam logic [7:0] MAX_POS      = 8'hFF;

	localparam logic [2:0] TYPE_JOIN_REQ = 3'd0;
	localparam logic [2:0] TYPE_JOIN_ACC = 3'd1;
	localparam logic [2:0] TYPE_REJOIN   = 3'd6;
	localparam logic [2:0] TYPE_PROP     = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  msg_type;
		logic [4:0]  version_bits;
		logic        frame_ok;
		logic [63:0] first_identifier;
		logic [63:0] device_eui;
		logic [15:0] counter_or_nonce;
		logic [7:0]  frame_control;
		logic [7:0]  port_number;
		logic [7:0]  payload_length;
		logic [31:0] integrity_code;
		logic [7:0]  frame_length;
	} hdr_item_t;

	typedef struct packed {
		logic [7:0]  byte_position;
		logic        length_overflow;
		logic [7:0]  header_byte;
		logic [63:0] identifier_low;
		logic [63:0] identifier_high;
		logic [15:0] count_word;
		logic [15:0] nonce_word;
		logic [7:0]  control_byte;
		logic [7:0]  port_capture;
		logic [31:0] tail_window;
	} frame_state_t;

	localparam frame_state_t FRAME_CLEAR = '{
		byte_position:   8'd0,
		length_overflow: 1'b0,
		header_byte:     8'd0,
		identifier_low:  64'd0,
		identifier_high: 64'd0,
		count_word:      16'd0,
		nonce_word:      16'd0,
		control_byte:    8'd0,
		port_capture:    NO_PORT,
		tail_window:     32'd0
	};

endpackage

// ----- rtl/lfhp_capture.sv -----
// per-byte capture of header fields, byte count and trailing window
// depends on lfhp_pkg
module lfhp_capture (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  lfhp_pkg::byte_item_t  item,
	output lfhp_pkg::frame_state_t state_next
);
	import lfhp_pkg::*;

	frame_state_t st_q;
	frame_state_t st_n;
	logic [7:0]   pos;
	logic [7:0]   b;
	logic [7:0]   port_pos;

	always_comb begin
		st_n     = st_q;
		pos      = st_q.byte_position;
		b        = item.data_byte;
		port_pos = {4'd0, st_q.control_byte[3:0] & FOPTS_MASK} + 8'd8;
		if (pos == 8'd0) begin
			st_n.header_byte = b;
		end
		for (int i = 0; i < 8; i++) begin
			if (pos == 8'(i + 1)) begin
				st_n.identifier_low[8*i +: 8] = b;
			end
			if (pos == 8'(i + 9)) begin
				st_n.identifier_high[8*i +: 8] = b;
			end
		end
		if (pos == 8'd5) begin
			st_n.control_byte = b;
		end
		if (pos == 8'd6) begin
			st_n.count_word[7:0] = b;
		end
		if (pos == 8'd7) begin
			st_n.count_word[15:8] = b;
		end
		if (pos == 8'd17) begin
			st_n.nonce_word[7:0] = b;
		end
		if (pos == 8'd18) begin
			st_n.nonce_word[15:8] = b;
		end
		if (pos == port_pos) begin
			st_n.port_capture = b;
		end
		st_n.tail_window = {b, st_q.tail_window[31:8]};
		if (pos == MAX_POS) begin
			st_n.length_overflow = 1'b1;
		end else begin
			st_n.byte_position = pos + 8'd1;
		end
	end

	assign state_next = st_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FRAME_CLEAR;
		end else if (go) begin
			st_q <= item.last_byte ? FRAME_CLEAR : st_n;
		end
	end

endmodule

// ----- rtl/lfhp_decode.sv -----
// field decode and validity check of a finished frame, result register
// depends on lfhp_pkg
module lfhp_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  lfhp_pkg::frame_state_t st,
	input  logic                   stall,
	output logic                   valid,
	output lfhp_pkg::hdr_item_t    data,
	output logic                   free
);
	import lfhp_pkg::*;

	logic [2:0]  ftype;
	logic [4:0]  ver;
	logic [7:0]  n;
	logic        join_f;
	logic        ok;
	logic [7:0]  hdr_end;
	logic        has_port;
	hdr_item_t   res;
	logic        valid_q;
	hdr_item_t   data_q;

	always_comb begin
		ftype    = st.header_byte[7:5];
		ver      = st.header_byte[4:0] & VERSION_MASK;
		n        = st.byte_position;
		join_f   = (ftype == TYPE_JOIN_REQ) || (ftype == TYPE_REJOIN);
		hdr_end  = 8'(DATA_MIN_LEN) + {4'd0, st.control_byte[3:0] & FOPTS_MASK};
		has_port = n > hdr_end;
		if (ver != 5'd0 || st.length_overflow) begin
			ok = 1'b0;
		end else if (ftype == TYPE_PROP) begin
			ok = 1'b0;
		end else if (join_f) begin
			ok = (n >= 8'(JOIN_MIN_LEN)) && (n <= 8'(JOIN_MAX_LEN));
		end else if (ftype == TYPE_JOIN_ACC) begin
			ok = (n == 8'(ACCEPT_LEN));
		end else begin
			ok = (n >= 8'(DATA_MIN_LEN));
		end
		res.msg_type         = ftype;
		res.version_bits     = ver;
		res.frame_ok         = ok;
		res.first_identifier = join_f ? st.identifier_low
		                              : {32'd0, st.identifier_low[31:0]};
		res.device_eui       = join_f ? st.identifier_high : 64'd0;
		res.counter_or_nonce = join_f ? st.nonce_word : st.count_word;
		res.frame_control    = st.control_byte;
		res.port_number      = has_port ? st.port_capture : NO_PORT;
		res.payload_length   = has_port ? (n - hdr_end - 8'd1) : 8'd0;
		res.integrity_code   = st.tail_window;
		res.frame_length     = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign free  = !valid_q || !stall;

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || !stall))
		else $error("result overwritten while stalled");

	a_ok_version: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && data_q.frame_ok) |-> (data_q.version_bits == 5'd0 &&
		data_q.msg_type != TYPE_PROP && data_q.frame_length >= 8'(DATA_MIN_LEN)))
		else $error("frame_ok set on a bad header");

	a_eui_join: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && data_q.device_eui != 64'd0) |->
		(data_q.msg_type == TYPE_JOIN_REQ || data_q.msg_type == TYPE_REJOIN))
		else $error("device eui on a non-join frame");

	a_no_port_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && data_q.payload_length != 8'd0) |->
		(data_q.frame_length > 8'(DATA_MIN_LEN)))
		else $error("payload on a frame too short for one");

endmodule

// ----- rtl/lorawan_frame_header_parser_core.sv -----
// frame header parser top level: input register, capture and decode
// depends on lfhp_pkg, lfhp_capture, lfhp_decode
// order: a transferred byte waits in the input register until capture takes it; the
//   result of a final byte is loaded into the result register as capture takes it
// throughput: one byte per cycle; the input register stalls only on a final
//   byte whose result slot is still held by a stalled result
// reset: asynchronous, clears the valid flags and capture state, no results pending
module lorawan_frame_header_parser_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  lfhp_pkg::byte_item_t byte_data,
	output logic                 hdr_valid,
	input  logic                 hdr_stall,
	output lfhp_pkg::hdr_item_t  hdr_data
);
	import lfhp_pkg::*;

	logic         valid_s1;
	byte_item_t   item_s1;
	logic         go;
	logic         out_free;
	frame_state_t st_next;

	assign go         = valid_s1 && (!item_s1.last_byte || out_free);
	assign byte_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	lfhp_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.item       (item_s1),
		.state_next (st_next)
	);

	lfhp_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (go && item_s1.last_byte),
		.st     (st_next),
		.stall  (hdr_stall),
		.valid  (hdr_valid),
		.data   (hdr_data),
		.free   (out_free)
	);

endmodule

// ----- tb/sv/tb_lorawan_frame_header_parser_core.sv -----
// self-checking testbench for lorawan_frame_header_parser_core: sends frames byte by byte,
// predicts each decoded header and compares every field of every result transfer
// depends on lfhp_pkg and the core rtl
module tb_lorawan_frame_header_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lfhp_pkg::*;

	localparam logic [2:0] TYPE_DATA_FIRST = 3'd2;
	localparam logic [2:0] TYPE_DATA_LAST  = 3'd5;
	localparam int RUN_LIMIT_NS = 5_000_000;
	localparam int HOLD_CYCLES = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_item_t byte_data = '0;
	logic       hdr_valid;
	logic       hdr_stall = 1'b0;
	hdr_item_t  hdr_data;

	hdr_item_t   expected_headers[$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_end = 0;

	// frame capture state of the predictor
	logic [7:0]  pos_q;
	logic        ovf_q;
	logic [7:0]  mhdr_q;
	logic [63:0] id_lo_q;
	logic [63:0] id_hi_q;
	logic [15:0] fcnt_q;
	logic [15:0] nonce_q;
	logic [7:0]  fctrl_q;
	logic [7:0]  fport_q;
	logic [31:0] mic_q;

	lorawan_frame_header_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.hdr_valid (hdr_valid),
		.hdr_stall (hdr_stall),
		.hdr_data  (hdr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	function automatic void clear_frame_capture();
		pos_q   = 8'd0;
		ovf_q   = 1'b0;
		mhdr_q  = 8'd0;
		id_lo_q = 64'd0;
		id_hi_q = 64'd0;
		fcnt_q  = 16'd0;
		nonce_q = 16'd0;
		fctrl_q = 8'd0;
		fport_q = NO_PORT;
		mic_q   = 32'd0;
	endfunction

	function automatic bit parse_header_byte(input byte_item_t item, output hdr_item_t hdr);
		int         pos;
		int         n;
		int         hdr_end;
		logic [7:0] b;
		logic [2:0] ftype;
		logic [4:0] ver;
		bit         join_frame;
		bit         ok;
		hdr = '0;
		b = item.data_byte;
		pos = int'(pos_q);
		if (pos == 0) mhdr_q = b;
		if (pos >= 1 && pos <= 8) id_lo_q[8 * (pos - 1) +: 8] = id_lo_q[8 * (pos - 1) +: 8] | b;
		if (pos >= 9 && pos <= 16) id_hi_q[8 * (pos - 9) +: 8] = id_hi_q[8 * (pos - 9) +: 8] | b;
		if (pos == 5) fctrl_q = b;
		if (pos == 6) fcnt_q[7:0] = b;
		if (pos == 7) fcnt_q[15:8] = b;
		if (pos == 17) nonce_q[7:0] = b;
		if (pos == 18) nonce_q[15:8] = b;
		if (pos >= 8 && pos == 8 + int'(fctrl_q[3:0] & FOPTS_MASK)) fport_q = b;
		mic_q = {b, mic_q[31:8]};
		if (pos_q == MAX_POS) ovf_q = 1'b1;
		else pos_q = pos_q + 8'd1;
		if (!item.last_byte) return 1'b0;

		ftype = mhdr_q[7:5];
		ver = mhdr_q[4:0] & VERSION_MASK;
		n = int'(pos_q);
		join_frame = (ftype == TYPE_JOIN_REQ || ftype == TYPE_REJOIN);
		if (ver != 5'd0 || ovf_q) ok = 1'b0;
		else if (ftype == TYPE_PROP) ok = 1'b0;
		else if (join_frame) ok = (n >= JOIN_MIN_LEN && n <= JOIN_MAX_LEN);
		else if (ftype == TYPE_JOIN_ACC) ok = (n == ACCEPT_LEN);
		else ok = (n >= DATA_MIN_LEN);
		hdr_end = DATA_MIN_LEN + int'(fctrl_q[3:0] & FOPTS_MASK);

		hdr.msg_type         = ftype;
		hdr.version_bits     = ver;
		hdr.frame_ok         = ok;
		hdr.first_identifier = join_frame ? id_lo_q : {32'd0, id_lo_q[31:0]};
		hdr.device_eui       = join_frame ? id_hi_q : 64'd0;
		hdr.counter_or_nonce = join_frame ? nonce_q : fcnt_q;
		hdr.frame_control    = fctrl_q;
		hdr.port_number      = (n > hdr_end) ? fport_q : NO_PORT;
		hdr.payload_length   = (n > hdr_end) ? 8'(n - hdr_end - 1) : 8'd0;
		hdr.integrity_code   = mic_q;
		hdr.frame_length     = 8'(n);
		clear_frame_capture();
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// result checker
	always @(posedge clk) begin : hdr_checker
		hdr_item_t want;
		if (arst_n && hdr_valid && !hdr_stall) begin
			if (expected_headers.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result transfer: expected none actual %h",
					$time, hdr_data);
			end else begin
				want = expected_headers.pop_front();
				check_field("msg_type", 64'(want.msg_type), 64'(hdr_data.msg_type));
				check_field("version_bits", 64'(want.version_bits),
					64'(hdr_data.version_bits));
				check_field("frame_ok", 64'(want.frame_ok), 64'(hdr_data.frame_ok));
				check_field("first_identifier", want.first_identifier,
					hdr_data.first_identifier);
				check_field("device_eui", want.device_eui, hdr_data.device_eui);
				check_field("counter_or_nonce", 64'(want.counter_or_nonce),
					64'(hdr_data.counter_or_nonce));
				check_field("frame_control", 64'(want.frame_control),
					64'(hdr_data.frame_control));
				check_field("port_number", 64'(want.port_number),
					64'(hdr_data.port_number));
				check_field("payload_length", 64'(want.payload_length),
					64'(hdr_data.payload_length));
				check_field("integrity_code", 64'(want.integrity_code),
					64'(hdr_data.integrity_code));
				check_field("frame_length", 64'(want.frame_length),
					64'(hdr_data.frame_length));
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count < hold_end) begin
			hdr_stall <= 1'b1;
		end else begin
			hdr_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_byte(input byte_item_t item);
		hdr_item_t hdr;
		int        gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= item;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		if (parse_header_byte(item, hdr)) expected_headers.push_back(hdr);
		bytes_sent++;
	endtask

	// fopts < 0 leaves FCtrl as drawn; fill < 0 draws random content
	task automatic send_frame(input logic [7:0] mhdr, input int len, input int fopts,
			input int fill);
		byte_item_t item;
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if (i == 0) b = mhdr;
			else if (fill >= 0) b = 8'(fill);
			else b = 8'($urandom_range(255));
			if (i == 5 && fopts >= 0) b = {b[7:4], 4'(fopts)};
			item.data_byte = b;
			item.last_byte = (i == len - 1);
			send_byte(item);
		end
	endtask

	task automatic wait_results_done();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (expected_headers.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_frame();
		int         kind;
		int         len;
		int         fopts;
		logic [2:0] ftype;
		logic [4:0] ver;
		kind = $urandom_range(99);
		ftype = 3'($urandom_range(7));
		ver = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'd0;
		fopts = $urandom_range(15);
		if (kind < 2) begin
			len = $urandom_range(250, 270);
		end else if (kind < 15) begin
			ver = 5'($urandom_range(31));
			len = $urandom_range(1, 40);
			fopts = -1;
		end else if (ftype == TYPE_JOIN_REQ || ftype == TYPE_REJOIN) begin
			len = $urandom_range(JOIN_MIN_LEN - 1, JOIN_MAX_LEN + 1);
		end else if (ftype == TYPE_JOIN_ACC) begin
			len = $urandom_range(ACCEPT_LEN - 1, ACCEPT_LEN + 1);
		end else begin
			len = $urandom_range(DATA_MIN_LEN, DATA_MIN_LEN + fopts + 24);
		end
		send_frame({ftype, ver}, len, fopts, -1);
	endtask

	task automatic test_short_frames();
		send_frame({TYPE_DATA_FIRST, 5'd0}, 1, -1, -1);
		send_frame({TYPE_DATA_FIRST, 5'd0}, 2, -1, -1);
		send_frame({TYPE_JOIN_REQ, 5'd0}, 3, -1, -1);
		send_frame({TYPE_DATA_LAST, 5'd0}, 4, -1, -1);
		send_frame(8'h00, DATA_MIN_LEN, -1, 0);
		send_frame(8'hFF, DATA_MIN_LEN, -1, 255);
		wait_results_done();
	endtask

	task automatic test_frame_types();
		send_frame({TYPE_JOIN_REQ, 5'd0}, 23, -1, -1);
		send_frame({TYPE_JOIN_ACC, 5'd0}, ACCEPT_LEN, -1, -1);
		for (int t = int'(TYPE_DATA_FIRST); t <= int'(TYPE_DATA_LAST); t++)
			send_frame({3'(t), 5'd0}, 20, $urandom_range(15), -1);
		send_frame({TYPE_REJOIN, 5'd0}, 19, -1, -1);
		send_frame({TYPE_PROP, 5'd0}, 20, -1, -1);
		send_frame({TYPE_DATA_FIRST, 5'd1}, 20, 0, -1);
		send_frame({TYPE_JOIN_REQ, VERSION_MASK}, 23, -1, -1);
		wait_results_done();
	endtask

	task automatic test_length_bounds();
		send_frame({TYPE_JOIN_REQ, 5'd0}, JOIN_MIN_LEN - 1, -1, -1);
		send_frame({TYPE_JOIN_REQ, 5'd0}, JOIN_MIN_LEN, -1, -1);
		send_frame({TYPE_REJOIN, 5'd0}, JOIN_MAX_LEN, -1, -1);
		send_frame({TYPE_REJOIN, 5'd0}, JOIN_MAX_LEN + 1, -1, -1);
		send_frame({TYPE_JOIN_ACC, 5'd0}, ACCEPT_LEN - 1, -1, -1);
		send_frame({TYPE_JOIN_ACC, 5'd0}, ACCEPT_LEN + 1, -1, -1);
		send_frame({TYPE_DATA_FIRST, 5'd0}, DATA_MIN_LEN - 1, 0, -1);
		send_frame({TYPE_DATA_LAST, 5'd0}, DATA_MIN_LEN, 0, -1);
		wait_results_done();
	endtask

	// port just beside the MIC, with the widest and narrowest option field
	task automatic test_option_port();
		send_frame({TYPE_DATA_FIRST, 5'd0}, DATA_MIN_LEN + 15, 15, -1);
		send_frame({TYPE_DATA_FIRST, 5'd0}, DATA_MIN_LEN + 16, 15, -1);
		send_frame({TYPE_DATA_LAST, 5'd0}, DATA_MIN_LEN + 1, 0, -1);
		send_frame({TYPE_JOIN_REQ, 5'd0}, JOIN_MAX_LEN, 7, -1);
		wait_results_done();
	endtask

	task automatic test_long_frames();
		send_frame({TYPE_DATA_FIRST, 5'd0}, 255, -1, -1);
		send_frame({TYPE_DATA_FIRST, 5'd0}, 256, -1, -1);
		send_frame({TYPE_JOIN_REQ, 5'd0}, 300, -1, -1);
		wait_results_done();
	endtask

	task automatic test_random_frames(input int idle, input int stall, input int budget);
		int start;
		idle_pct = idle;
		stall_pct = stall;
		start = bytes_sent;
		while (bytes_sent - start < budget) send_random_frame();
		wait_results_done();
	endtask

	// receiver holds off while short frames keep coming, so the input must stall
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_end = cycle_count + HOLD_CYCLES;
		repeat (60) send_frame(8'($urandom_range(255)), $urandom_range(1, 4), -1, -1);
		wait_results_done();
	endtask

	initial begin
		clear_frame_capture();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_frames();
		test_frame_types();
		test_length_bounds();
		test_option_port();
		test_long_frames();
		test_random_frames(0, 0, 130);
		test_random_frames(55, 0, 130);
		test_random_frames(0, 55, 130);
		test_random_frames(19, 19, 130);
		test_backpressure();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_headers.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/lfhp_pkg.sv
rtl/lfhp_capture.sv
rtl/lfhp_decode.sv
rtl/lorawan_frame_header_parser_core.sv
tb/sv/tb_lorawan_frame_header_parser_core.sv
